@@ hw/rtl/tsu_pkg.sv @@
// shared types, codes and constants for the two-process tick scheduler
`default_nettype none

package tsu_pkg;

	// configuration register widths
	localparam int unsigned CFG_W       = 16;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned QUANT_W     = 16;
	localparam int unsigned BURST_W_DEF = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BURST_A  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IO_BURST_A     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_BURST_A = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BURST_B  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IO_BURST_B     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_BURST_B = 3'd7;

	// scheduling policies
	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_PSJF = 2'd2;
	localparam logic [1:0] POL_RR   = 2'd3;

	// process status codes, also the report codes
	localparam logic [1:0] ST_READY = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	// process phases
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_IO     = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;
	localparam logic [1:0] PH_FIN    = 2'd3;

	// round robin owner codes
	localparam logic [1:0] OWN_NONE = 2'd0;
	localparam logic [1:0] OWN_A    = 2'd1;
	localparam logic [1:0] OWN_B    = 2'd2;

	// process index
	localparam int unsigned PROC_A = 0;
	localparam int unsigned PROC_B = 1;

	typedef struct packed {
		logic [1:0]       policy;
		logic [QUANT_W-1:0] quantum;
		logic [CFG_W-1:0] first_burst_a;
		logic [CFG_W-1:0] io_burst_a;
		logic [CFG_W-1:0] second_burst_a;
		logic [CFG_W-1:0] first_burst_b;
		logic [CFG_W-1:0] io_burst_b;
		logic [CFG_W-1:0] second_burst_b;
	} cfg_t;

	typedef struct packed {
		logic [1:0] ph;
		logic [1:0] st;
	} ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/two_process_tick_scheduler_unit.sv @@
// top level of the two-process tick scheduler
//
// usage:
//   one input beat is one scheduler tick; its only field, restart, reloads both
//   processes from the configuration registers before the tick is applied.
//   every tick yields exactly one output beat: report_a, report_b (0 ready,
//   1 running, 2 waiting, 3 done) and all_done.
//   configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata): index 0
//   policy, 1 quantum, 2..7 bursts. it is to be written only while no tick is in
//   flight; the user must ensure this, the block itself has no check for it.
// pipeline and throughput:
//   an accepted beat lands in the input stage, the tick is evaluated from there
//   in one pass of small logic and the result is registered; one tick per cycle
//   is sustained while out_stall is low, set by tsu_step's state update loop.
// stalls:
//   the output register holds its beat while out_stall is high; the input
//   stage still takes one more beat, then in_stall rises until the output frees.
// reset:
//   arst_n resets all but the payload; both processes read as done (all_done 1)
//   until a tick with restart arrives. configuration returns to fcfs, quantum 1.
`default_nettype none

module two_process_tick_scheduler_unit #(
	parameter int unsigned BURST_WIDTH = tsu_pkg::BURST_W_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [tsu_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [tsu_pkg::CFG_W-1:0]     cfg_wdata,
	// tick input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          restart,
	// report output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         report_a,
	output logic [1:0]                         report_b,
	output logic                               all_done
);

	tsu_pkg::cfg_t cfg;

	// input stage
	logic valid_s1;
	logic restart_s1;

	// scheduler state
	logic [1:0][BURST_WIDTH-1:0] b1_q, io_q, b2_q;
	tsu_pkg::ctrl_t [1:0]        ctrl_q;
	logic [1:0]                  owner_q;
	logic [tsu_pkg::QUANT_W-1:0] ql_q;

	// next state from the step logic
	logic [1:0][BURST_WIDTH-1:0] b1_nxt, io_nxt, b2_nxt;
	tsu_pkg::ctrl_t [1:0]        ctrl_nxt;
	logic [1:0]                  owner_nxt;
	logic [tsu_pkg::QUANT_W-1:0] ql_nxt;
	logic [1:0]                  rep_a_nxt, rep_b_nxt;
	logic                        done_nxt;

	// output register
	logic       out_valid_q;
	logic [1:0] report_a_q, report_b_q;
	logic       all_done_q;

	logic in_take;
	logic s1_adv;

	tsu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tsu_step #(
		.BURST_WIDTH (BURST_WIDTH)
	) u_step (
		.cfg       (cfg),
		.restart   (restart_s1),
		.b1_cur    (b1_q),
		.io_cur    (io_q),
		.b2_cur    (b2_q),
		.ctrl_cur  (ctrl_q),
		.owner_cur (owner_q),
		.ql_cur    (ql_q),
		.b1_nxt    (b1_nxt),
		.io_nxt    (io_nxt),
		.b2_nxt    (b2_nxt),
		.ctrl_nxt  (ctrl_nxt),
		.owner_nxt (owner_nxt),
		.ql_nxt    (ql_nxt),
		.report_a  (rep_a_nxt),
		.report_b  (rep_b_nxt),
		.all_done  (done_nxt)
	);

	// tick leaves the input stage when the output register is free or draining
	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			restart_s1 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
				restart_s1 <= restart;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// state commits once per tick, as the tick moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_q <= '0;
			io_q <= '0;
			b2_q <= '0;
			// both processes finished and done
			ctrl_q <= {2{tsu_pkg::ctrl_t'{ph: tsu_pkg::PH_FIN, st: tsu_pkg::ST_DONE}}};
			owner_q <= tsu_pkg::OWN_NONE;
			ql_q <= '0;
		end else if (s1_adv) begin
			b1_q <= b1_nxt;
			io_q <= io_nxt;
			b2_q <= b2_nxt;
			ctrl_q <= ctrl_nxt;
			owner_q <= owner_nxt;
			ql_q <= ql_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			report_a_q <= rep_a_nxt;
			report_b_q <= rep_b_nxt;
			all_done_q <= done_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign report_a  = report_a_q;
	assign report_b  = report_b_q;
	assign all_done  = all_done_q;

endmodule

`default_nettype wire

@@ hw/rtl/tsu_cfg_regs.sv @@
// configuration register file of the tick scheduler
`default_nettype none

module tsu_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tsu_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [tsu_pkg::CFG_W-1:0]      cfg_wdata,
	output tsu_pkg::cfg_t                       cfg
);

	tsu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{policy: tsu_pkg::POL_FCFS, quantum: tsu_pkg::QUANT_W'(1), default: '0};
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tsu_pkg::REG_POLICY:         cfg_q.policy <= cfg_wdata[1:0];
				tsu_pkg::REG_QUANTUM:        cfg_q.quantum <= cfg_wdata;
				tsu_pkg::REG_FIRST_BURST_A:  cfg_q.first_burst_a <= cfg_wdata;
				tsu_pkg::REG_IO_BURST_A:     cfg_q.io_burst_a <= cfg_wdata;
				tsu_pkg::REG_SECOND_BURST_A: cfg_q.second_burst_a <= cfg_wdata;
				tsu_pkg::REG_FIRST_BURST_B:  cfg_q.first_burst_b <= cfg_wdata;
				tsu_pkg::REG_IO_BURST_B:     cfg_q.io_burst_b <= cfg_wdata;
				tsu_pkg::REG_SECOND_BURST_B: cfg_q.second_burst_b <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/tsu_step.sv @@
// one scheduler tick: reload on restart, close bursts, pick the runner, report, count down
`default_nettype none

module tsu_step #(
	parameter int unsigned BURST_WIDTH = tsu_pkg::BURST_W_DEF
) (
	input  wire tsu_pkg::cfg_t                     cfg,
	input  wire logic                              restart,
	input  wire logic [1:0][BURST_WIDTH-1:0]       b1_cur,
	input  wire logic [1:0][BURST_WIDTH-1:0]       io_cur,
	input  wire logic [1:0][BURST_WIDTH-1:0]       b2_cur,
	input  wire tsu_pkg::ctrl_t [1:0]              ctrl_cur,
	input  wire logic [1:0]                        owner_cur,
	input  wire logic [tsu_pkg::QUANT_W-1:0]       ql_cur,
	output logic [1:0][BURST_WIDTH-1:0]            b1_nxt,
	output logic [1:0][BURST_WIDTH-1:0]            io_nxt,
	output logic [1:0][BURST_WIDTH-1:0]            b2_nxt,
	output tsu_pkg::ctrl_t [1:0]                   ctrl_nxt,
	output logic [1:0]                             owner_nxt,
	output logic [tsu_pkg::QUANT_W-1:0]            ql_nxt,
	output logic [1:0]                             report_a,
	output logic [1:0]                             report_b,
	output logic                                   all_done
);

	logic [1:0][BURST_WIDTH-1:0] b1, io, b2, left;
	tsu_pkg::ctrl_t [1:0]        ctrl;
	logic [1:0]                  owner;
	logic [tsu_pkg::QUANT_W-1:0] ql;
	logic [1:0]                  elig;
	logic                        expired_a;
	logic                        ca, cb, rr_run;

	always_comb begin
		b1 = b1_cur;
		io = io_cur;
		b2 = b2_cur;
		ctrl = ctrl_cur;
		owner = owner_cur;
		ql = ql_cur;
		elig = '0;
		left = '0;
		expired_a = 1'b0;
		ca = 1'b0;
		cb = 1'b0;

		// reload from configuration
		if (restart) begin
			b1[tsu_pkg::PROC_A] = BURST_WIDTH'(cfg.first_burst_a);
			io[tsu_pkg::PROC_A] = BURST_WIDTH'(cfg.io_burst_a);
			b2[tsu_pkg::PROC_A] = BURST_WIDTH'(cfg.second_burst_a);
			b1[tsu_pkg::PROC_B] = BURST_WIDTH'(cfg.first_burst_b);
			io[tsu_pkg::PROC_B] = BURST_WIDTH'(cfg.io_burst_b);
			b2[tsu_pkg::PROC_B] = BURST_WIDTH'(cfg.second_burst_b);
			for (int p = 0; p < 2; p++) begin
				ctrl[p].ph = tsu_pkg::PH_FIRST;
				ctrl[p].st = tsu_pkg::ST_READY;
			end
			owner = tsu_pkg::OWN_NONE;
			ql = '0;
		end

		// close finished cpu bursts
		for (int p = 0; p < 2; p++) begin
			if (ctrl[p].st == tsu_pkg::ST_RUN) begin
				if (ctrl[p].ph == tsu_pkg::PH_FIRST && b1[p] == '0) begin
					if (io[p] == '0) begin
						ctrl[p].ph = tsu_pkg::PH_FIN;
						ctrl[p].st = tsu_pkg::ST_DONE;
					end else begin
						ctrl[p].ph = tsu_pkg::PH_IO;
						ctrl[p].st = tsu_pkg::ST_WAIT;
					end
				end else if (ctrl[p].ph == tsu_pkg::PH_SECOND && b2[p] == '0) begin
					ctrl[p].ph = tsu_pkg::PH_FIN;
					ctrl[p].st = tsu_pkg::ST_DONE;
				end
			end
		end

		if (cfg.policy == tsu_pkg::POL_RR) begin
			// owner gives up the slice when it finishes or goes to i/o
			if (owner == tsu_pkg::OWN_A && (ctrl[tsu_pkg::PROC_A].ph == tsu_pkg::PH_FIN ||
					ctrl[tsu_pkg::PROC_A].st == tsu_pkg::ST_WAIT)) begin
				owner = tsu_pkg::OWN_NONE;
			end
			if (owner == tsu_pkg::OWN_B && (ctrl[tsu_pkg::PROC_B].ph == tsu_pkg::PH_FIN ||
					ctrl[tsu_pkg::PROC_B].st == tsu_pkg::ST_WAIT)) begin
				owner = tsu_pkg::OWN_NONE;
			end
		end

		// close finished i/o
		for (int p = 0; p < 2; p++) begin
			if (ctrl[p].st == tsu_pkg::ST_WAIT && ctrl[p].ph == tsu_pkg::PH_IO &&
					io[p] == '0) begin
				ctrl[p].ph = tsu_pkg::PH_SECOND;
				ctrl[p].st = tsu_pkg::ST_READY;
			end
		end

		if (cfg.policy == tsu_pkg::POL_RR) begin
			// quantum expiry
			if (owner == tsu_pkg::OWN_A && ctrl[tsu_pkg::PROC_A].st == tsu_pkg::ST_RUN) begin
				if (ql == '0) begin
					ctrl[tsu_pkg::PROC_A].st = tsu_pkg::ST_READY;
					owner = tsu_pkg::OWN_NONE;
					expired_a = 1'b1;
				end
			end else if (owner == tsu_pkg::OWN_B &&
					ctrl[tsu_pkg::PROC_B].st == tsu_pkg::ST_RUN) begin
				if (ql == '0) begin
					ctrl[tsu_pkg::PROC_B].st = tsu_pkg::ST_READY;
					owner = tsu_pkg::OWN_NONE;
				end
			end
			if (owner == tsu_pkg::OWN_NONE) begin
				for (int p = 0; p < 2; p++) begin
					elig[p] = ctrl[p].st == tsu_pkg::ST_READY && ctrl[p].ph != tsu_pkg::PH_FIN;
				end
				// after a expires, b goes first
				if (expired_a) begin
					if (elig[tsu_pkg::PROC_B]) begin
						owner = tsu_pkg::OWN_B;
						ctrl[tsu_pkg::PROC_B].st = tsu_pkg::ST_RUN;
					end else if (elig[tsu_pkg::PROC_A]) begin
						owner = tsu_pkg::OWN_A;
						ctrl[tsu_pkg::PROC_A].st = tsu_pkg::ST_RUN;
					end
				end else begin
					if (elig[tsu_pkg::PROC_A]) begin
						owner = tsu_pkg::OWN_A;
						ctrl[tsu_pkg::PROC_A].st = tsu_pkg::ST_RUN;
					end else if (elig[tsu_pkg::PROC_B]) begin
						owner = tsu_pkg::OWN_B;
						ctrl[tsu_pkg::PROC_B].st = tsu_pkg::ST_RUN;
					end
				end
				if (owner != tsu_pkg::OWN_NONE) begin
					ql = cfg.quantum;
				end
			end
		end else begin
			for (int p = 0; p < 2; p++) begin
				elig[p] = ctrl[p].st == tsu_pkg::ST_READY && ctrl[p].ph != tsu_pkg::PH_FIN;
				if (ctrl[p].ph == tsu_pkg::PH_FIRST) begin
					left[p] = b1[p];
				end else if (ctrl[p].ph == tsu_pkg::PH_SECOND) begin
					left[p] = b2[p];
				end
			end
			unique case (cfg.policy)
				tsu_pkg::POL_FCFS, tsu_pkg::POL_SJF: begin
					if (ctrl[tsu_pkg::PROC_A].st != tsu_pkg::ST_RUN &&
							ctrl[tsu_pkg::PROC_B].st != tsu_pkg::ST_RUN) begin
						if (elig[tsu_pkg::PROC_A] && elig[tsu_pkg::PROC_B] &&
								cfg.policy == tsu_pkg::POL_SJF) begin
							if (left[tsu_pkg::PROC_A] <= left[tsu_pkg::PROC_B]) begin
								ctrl[tsu_pkg::PROC_A].st = tsu_pkg::ST_RUN;
							end else begin
								ctrl[tsu_pkg::PROC_B].st = tsu_pkg::ST_RUN;
							end
						end else if (elig[tsu_pkg::PROC_A]) begin
							ctrl[tsu_pkg::PROC_A].st = tsu_pkg::ST_RUN;
						end else if (elig[tsu_pkg::PROC_B]) begin
							ctrl[tsu_pkg::PROC_B].st = tsu_pkg::ST_RUN;
						end
					end
				end
				default: begin
					// preemptive sjf, re-decided only when someone is ready
					if (elig != '0) begin
						ca = ctrl[tsu_pkg::PROC_A].st == tsu_pkg::ST_RUN || elig[tsu_pkg::PROC_A];
						cb = ctrl[tsu_pkg::PROC_B].st == tsu_pkg::ST_RUN || elig[tsu_pkg::PROC_B];
						for (int p = 0; p < 2; p++) begin
							if (ctrl[p].st == tsu_pkg::ST_RUN) begin
								ctrl[p].st = tsu_pkg::ST_READY;
							end
						end
						if (ca && (!cb || left[tsu_pkg::PROC_A] <= left[tsu_pkg::PROC_B])) begin
							ctrl[tsu_pkg::PROC_A].st = tsu_pkg::ST_RUN;
						end else begin
							ctrl[tsu_pkg::PROC_B].st = tsu_pkg::ST_RUN;
						end
					end
				end
			endcase
		end

		report_a = ctrl[tsu_pkg::PROC_A].st;
		report_b = ctrl[tsu_pkg::PROC_B].st;
		all_done = ctrl[tsu_pkg::PROC_A].ph == tsu_pkg::PH_FIN &&
			ctrl[tsu_pkg::PROC_B].ph == tsu_pkg::PH_FIN;

		rr_run = cfg.policy == tsu_pkg::POL_RR &&
			((ctrl[tsu_pkg::PROC_A].st == tsu_pkg::ST_RUN && owner == tsu_pkg::OWN_A) ||
			 (ctrl[tsu_pkg::PROC_B].st == tsu_pkg::ST_RUN && owner == tsu_pkg::OWN_B));

		// count down the running burst and the waiting i/o
		for (int p = 0; p < 2; p++) begin
			if (ctrl[p].st == tsu_pkg::ST_RUN) begin
				if (ctrl[p].ph == tsu_pkg::PH_FIRST && b1[p] != '0) begin
					b1[p] = b1[p] - BURST_WIDTH'(1);
				end else if (ctrl[p].ph == tsu_pkg::PH_SECOND && b2[p] != '0) begin
					b2[p] = b2[p] - BURST_WIDTH'(1);
				end
			end else if (ctrl[p].st == tsu_pkg::ST_WAIT) begin
				if (ctrl[p].ph == tsu_pkg::PH_IO && io[p] != '0) begin
					io[p] = io[p] - BURST_WIDTH'(1);
				end
			end
		end
		if (rr_run && ql != '0) begin
			ql = ql - tsu_pkg::QUANT_W'(1);
		end

		b1_nxt = b1;
		io_nxt = io;
		b2_nxt = b2;
		ctrl_nxt = ctrl;
		owner_nxt = owner;
		ql_nxt = ql;
	end

endmodule

`default_nettype wire

@@ hw/rtl/tsu_checker.sv @@
// port-level checks for the tick scheduler and their bind
`default_nettype none

module tsu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] report_a,
	input wire logic [1:0] report_b,
	input wire logic       all_done
);

	// a held output beat stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// input backpressure only comes from a stalled full output register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// an accepted tick is followed by an offered output beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("tick result missing");

	// both processes finished means both report done
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_done |-> report_a == tsu_pkg::ST_DONE && report_b == tsu_pkg::ST_DONE)
		else $error("all_done with a process not done");

endmodule

bind two_process_tick_scheduler_unit tsu_checker u_tsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.report_a  (report_a),
	.report_b  (report_b),
	.all_done  (all_done)
);

`default_nettype wire
